@@ design/binary_to_decimal_ascii_assert.svh @@
// assertion macros used by the port-level checker
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b2d check failed");

// next-cycle implication, checked outside reset
`define B2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b2d check failed");

`endif

@@ design/b2d_pkg.sv @@
// shared types and constants of the decimal text converter
package b2d_pkg;

    localparam int VALUE_W        = 32;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 8;
    localparam int BITS_PER_CYCLE = 4;
    localparam int SHORT_BITS     = 16;
    localparam int SHORT_DIGITS   = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int FMT_W          = 2;
    localparam int BLANK_W        = 4;

    typedef logic [FMT_W-1:0] t_fmt;

    localparam t_fmt FMT_S16 = 2'd0;
    localparam t_fmt FMT_U16 = 2'd1;
    localparam t_fmt FMT_S32 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 2'd1;

    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    // converter status handed to the character emitter
    typedef struct packed {
        logic full;
        logic neg;
        logic short_fmt;
    } t_conv_stat;

endpackage

@@ design/binary_to_decimal_ascii.sv @@
// top level of the binary to decimal ascii converter
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_stall     i_value_bits
//   out      output     o_out_valid / i_out_stall   o_character, o_last_char
//   cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// the bcd cell row takes 4 value bits a cycle; 16-bit formats shift in only a 16-bit magnitude
// characters leave one a cycle while the output is not stalled, 11 per item in signed 32-bit and 6 in 16-bit formats
// the next item converts while the previous one is emitted
// synchronous active-low reset clears control state; format resets to signed 32-bit
// a stall on the output holds the character register and backs up into o_in_stall
module binary_to_decimal_ascii import b2d_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_W-1:0]    i_value_bits,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAR_W-1:0]     o_character,
    output logic                  o_last_char,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_fmt               r_fmt;
    logic [BLANK_W-1:0] r_blank;

    t_conv_stat                    conv_stat;
    logic [MAX_DIGITS*DIGIT_W-1:0] conv_digits;
    logic                          take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_S32;
            r_blank <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FORMAT: r_fmt   <= i_cfg_data[FMT_W-1:0];
                CFG_BLANK:  r_blank <= i_cfg_data[BLANK_W-1:0];
                default: ;
            endcase
        end
    end

    b2d_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_value_bits (i_value_bits),
        .i_fmt        (r_fmt),
        .i_take       (take),
        .o_stall      (o_in_stall),
        .o_stat       (conv_stat),
        .o_digits     (conv_digits)
    );

    b2d_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat        (conv_stat),
        .i_digits      (conv_digits),
        .i_blank_count (r_blank),
        .o_take        (take),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_character   (o_character),
        .o_last_char   (o_last_char)
    );

endmodule

@@ design/b2d_cell.sv @@
// one bcd digit cell of the shift-and-add-3 chain
module b2d_cell import b2d_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_clr,
    input  logic                      i_en,
    input  logic [BITS_PER_CYCLE-1:0] i_bits,
    output logic [BITS_PER_CYCLE-1:0] o_bits,
    output logic [DIGIT_W-1:0]        o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;

    // several adjust-and-shift steps per cycle, step 0 first
    always_comb begin
        logic [DIGIT_W-1:0] d;
        logic [DIGIT_W-1:0] a;
        d = r_digit;
        for (int j = 0; j < BITS_PER_CYCLE; j++) begin
            a = (d >= 4'd5) ? d + 4'd3 : d;
            o_bits[j] = a[DIGIT_W-1];
            d = {a[DIGIT_W-2:0], i_bits[j]};
        end
        n_digit = d;
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_digit <= '0;
        end else if (i_en) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

@@ design/b2d_conv.sv @@
// magnitude extraction and binary to bcd conversion over a row of digit cells
module b2d_conv import b2d_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [VALUE_W-1:0]            i_value_bits,
    input  t_fmt                          i_fmt,
    input  logic                          i_take,
    output logic                          o_stall,
    output t_conv_stat                    o_stat,
    output logic [MAX_DIGITS*DIGIT_W-1:0] o_digits
);

    localparam int LONG_CYC  = VALUE_W / BITS_PER_CYCLE;
    localparam int SHORT_CYC = SHORT_BITS / BITS_PER_CYCLE;
    localparam int CNT_W     = $clog2(LONG_CYC + 1);

    logic               r_busy, n_busy;
    logic               r_full, n_full;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_sh;
    logic               r_neg;
    logic               r_short;

    logic                  accept;
    logic                  is_short;
    logic                  neg16;
    logic                  neg32;
    logic [SHORT_BITS-1:0] v16;
    logic [SHORT_BITS-1:0] mag16;
    logic [VALUE_W-1:0]    mag32;
    logic [VALUE_W-1:0]    load_sh;

    logic [BITS_PER_CYCLE-1:0] w_bits [MAX_DIGITS];

    assign o_stall = r_busy || (r_full && !i_take);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        is_short = !i_fmt[1];
        v16      = i_value_bits[SHORT_BITS-1:0];
        neg16    = (i_fmt == FMT_S16) && v16[SHORT_BITS-1];
        mag16    = neg16 ? (~v16 + 1'b1) : v16;
        neg32    = i_value_bits[VALUE_W-1];
        mag32    = neg32 ? (~i_value_bits + 1'b1) : i_value_bits;
        // 16-bit magnitudes sit at the top so fewer cycles shift them in
        load_sh  = is_short ? {mag16, {(VALUE_W-SHORT_BITS){1'b0}}} : mag32;
    end

    always_comb begin
        n_busy = r_busy;
        n_full = r_full;
        if (i_take) begin
            n_full = 1'b0;
        end
        if (r_busy && r_cnt == CNT_W'(1)) begin
            n_busy = 1'b0;
            n_full = 1'b1;
        end
        if (accept) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_full <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cnt   <= is_short ? CNT_W'(SHORT_CYC) : CNT_W'(LONG_CYC);
            r_sh    <= load_sh;
            r_neg   <= is_short ? neg16 : neg32;
            r_short <= is_short;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_sh  <= r_sh << BITS_PER_CYCLE;
        end
    end

    genvar g;
    generate
        for (g = 0; g < BITS_PER_CYCLE; g++) begin : g_feed
            assign w_bits[0][g] = r_sh[VALUE_W-1-g];
        end
        for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
            if (g < MAX_DIGITS - 1) begin : g_mid
                b2d_cell u_cell (
                    .i_clk   (i_clk),
                    .i_clr   (accept),
                    .i_en    (r_busy),
                    .i_bits  (w_bits[g]),
                    .o_bits  (w_bits[g+1]),
                    .o_digit (o_digits[g*DIGIT_W +: DIGIT_W])
                );
            end else begin : g_top
                // carry out of the top digit wraps the value modulo the digit span
                b2d_cell u_cell (
                    .i_clk   (i_clk),
                    .i_clr   (accept),
                    .i_en    (r_busy),
                    .i_bits  (w_bits[g]),
                    .o_bits  (),
                    .o_digit (o_digits[g*DIGIT_W +: DIGIT_W])
                );
            end
        end
    endgenerate

    assign o_stat = '{full: r_full, neg: r_neg, short_fmt: r_short};

endmodule

@@ design/b2d_emit.sv @@
// character emitter: sign column, digits, leading-zero blanking, output register
module b2d_emit import b2d_pkg::*; #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_conv_stat                    i_stat,
    input  logic [MAX_DIGITS*DIGIT_W-1:0] i_digits,
    input  logic [BLANK_W-1:0]            i_blank_count,
    output logic                          o_take,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [CHAR_W-1:0]             o_character,
    output logic                          o_last_char
);

    localparam int LEN_W       = $clog2(MAX_DIGITS + 2);
    localparam int DW          = MAX_DIGITS * DIGIT_W;
    localparam int SHORT_SHIFT = (MAX_DIGITS - SHORT_DIGITS) * DIGIT_W;

    logic [LEN_W-1:0]  r_left;
    logic [LEN_W-1:0]  r_pos;
    logic [DW-1:0]     r_digs;
    logic              r_neg;
    logic              r_zrun;
    logic              r_ovalid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic               advance;
    logic               produce;
    logic [DIGIT_W-1:0] top;
    logic               in_span;
    logic [CHAR_W-1:0]  next_char;
    logic [LEN_W-1:0]   len_new;

    assign advance = !r_ovalid || !i_out_stall;
    assign produce = advance && (r_left != '0);
    assign o_take  = i_stat.full && advance && (r_left <= LEN_W'(1));
    assign len_new = i_stat.short_fmt ? LEN_W'(SHORT_DIGITS + 1) : LEN_W'(MAX_DIGITS + 1);

    always_comb begin
        top     = r_digs[DW-1 -: DIGIT_W];
        in_span = BLANK_W'(r_pos) < i_blank_count;
        if (r_pos == '0) begin
            next_char = r_neg ? CH_MINUS : CH_BLANK;
        end else if (in_span && r_zrun && top == '0) begin
            next_char = CH_BLANK;
        end else begin
            next_char = CH_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_take) begin
                r_left <= len_new;
            end else if (produce) begin
                r_left <= r_left - 1'b1;
            end
            if (advance) begin
                r_ovalid <= (r_left != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pos  <= '0;
            r_digs <= i_stat.short_fmt ? (i_digits << SHORT_SHIFT) : i_digits;
            r_neg  <= i_stat.neg;
            r_zrun <= 1'b1;
        end else if (produce) begin
            r_pos <= r_pos + 1'b1;
            if (r_pos != '0) begin
                r_digs <= r_digs << DIGIT_W;
                // blanking stops at the first nonzero digit
                if (top != '0) begin
                    r_zrun <= 1'b0;
                end
            end
        end
        if (produce) begin
            r_char <= next_char;
            r_last <= (r_left == LEN_W'(1));
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

@@ design/b2d_checker.sv @@
// port-level checks on the converter, bound to the top level
`include "binary_to_decimal_ascii_assert.svh"

module b2d_checker import b2d_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last_char
);

    logic [CHAR_W:0] out_item;
    logic            char_ok;

    assign out_item = {o_last_char, o_character};
    assign char_ok  = o_character == CH_BLANK || o_character == CH_MINUS
                      || (o_character >= CH_ZERO && o_character <= (CH_ZERO + 8'd9));

    // a stalled item keeps its character
    `B2D_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_item))

    // only blanks, minus signs and decimal digits come out
    `B2D_ASSERT_NOW(a_char_set, o_out_valid, char_ok)

    // the sign column is never the final character
    `B2D_ASSERT_NOW(a_sign_not_last, o_out_valid && o_last_char, o_character != CH_MINUS)

    // the cell row is busy after an item enters, which stalls the input
    `B2D_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (.*);

@@ dv/binary_to_decimal_ascii_test.sv @@
// testbench for the binary to decimal ascii converter: predicted text checked per character
`timescale 1ns / 1ps

module binary_to_decimal_ascii_test;
    import b2d_pkg::*;

    localparam int DIGITS_32 = 10;
    localparam int TEXT_LEN  = DIGITS_32 + 1;
    localparam int LONG_HOLD = 80;

    localparam logic [CHAR_W-1:0]    CHAR_PLUS   = 8'h2B;
    localparam t_fmt                 FMT_UNDEF   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [VALUE_W-1:0]    i_value_bits;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CHAR_W-1:0]     o_character;
    logic                  o_last_char;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    class ascii_scoreboard;
        t_fmt               fmt;
        logic [BLANK_W-1:0] span_cfg;
        logic [CHAR_W-1:0]  pending_chars[$];
        logic               pending_last[$];
        int                 errors;

        function new();
            fmt      = FMT_S32;
            span_cfg = '0;
            errors   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FORMAT) begin
                fmt = data[FMT_W-1:0];
            end else if (idx == CFG_BLANK) begin
                span_cfg = data[BLANK_W-1:0];
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        // sign column plus digits, then the leading-zero blanking scan
        function void note_value(logic [VALUE_W-1:0] v);
            logic [CHAR_W-1:0]  text [0:TEXT_LEN-1];
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] rem;
            logic               neg;
            logic               stop;
            int                 nd;
            int                 len;
            int                 span;
            int                 k;
            if (fmt[1]) begin
                neg = v[31];
                mag = neg ? (32'd0 - v) : v;
                nd  = DIGITS_32;
            end else begin
                neg = (fmt == FMT_S16) && v[15];
                mag = neg ? (32'h1_0000 - {16'd0, v[15:0]}) : {16'd0, v[15:0]};
                nd  = SHORT_DIGITS;
            end
            len     = nd + 1;
            text[0] = neg ? CH_MINUS : CH_BLANK;
            for (k = nd; k >= 1; k--) begin
                rem     = mag % 10;
                text[k] = CH_ZERO + rem[CHAR_W-1:0];
                mag     = mag / 10;
            end
            span = (span_cfg > len) ? len : span_cfg;
            stop = 1'b0;
            for (k = 0; k < span; k++) begin
                if (!stop && text[k] != CH_BLANK && text[k] != CHAR_PLUS
                        && text[k] != CH_MINUS) begin
                    if (text[k] == CH_ZERO) begin
                        text[k] = CH_BLANK;
                    end else begin
                        stop = 1'b1;
                    end
                end
            end
            for (k = 0; k < len; k++) begin
                pending_chars.push_back(text[k]);
                pending_last.push_back(k == len - 1);
            end
        endfunction

        task report(string what, logic [CHAR_W-1:0] got, logic [CHAR_W-1:0] want);
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
            errors++;
        endtask

        task check_char(logic [CHAR_W-1:0] got_char, logic got_last);
            logic [CHAR_W-1:0] want_char;
            logic              want_last;
            if (pending_chars.size() == 0) begin
                report("unexpected character", got_char, 8'h00);
            end else begin
                want_char = pending_chars.pop_front();
                want_last = pending_last.pop_front();
                if (got_char !== want_char) begin
                    report("character", got_char, want_char);
                end
                if (got_last !== want_last) begin
                    report("last_char", {7'd0, got_last}, {7'd0, want_last});
                end
            end
        endtask
    endclass

    ascii_scoreboard sb = new();

    binary_to_decimal_ascii #(
        .MAX_DIGITS (DIGITS_32)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value_bits (i_value_bits),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_character  (o_character),
        .o_last_char  (o_last_char),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // all three channels observed at the edge that completes their handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_value(i_value_bits);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_char(o_character, o_last_char);
            end
        end
    end

    // receiver: random stall per character, plus one long hold on request
    initial begin
        int gap;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("binary_to_decimal_ascii_test failed");
        $finish;
    end

    task send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_value_bits <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // sender holds off until every predicted character has come out
    task wait_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    task write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task set_mode(input t_fmt fmt, input logic [BLANK_W-1:0] span);
        logic [1:0] junk;
        junk = 2'($urandom_range(0, 3));
        wait_until_drained();
        write_setting(CFG_FORMAT, {junk, fmt});
        write_setting(CFG_BLANK, span);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] p;
        logic [31:0]        r;
        int                 n;
        p = 32'd1;
        r = $urandom;
        case ($urandom_range(0, 4))
            0: p = $urandom;
            1: p = $urandom_range(0, 99);
            2: p = 32'd0 - $urandom_range(0, 99);
            3: begin
                n = $urandom_range(0, 9);
                repeat (n) p = p * 10;
                if (r[4]) p = 32'd0 - p;
            end
            default: begin
                case (r[1:0])
                    2'd0: p = {r[31:16], 16'h8000};
                    2'd1: p = {r[31:16], 16'h7FFF};
                    2'd2: p = 32'h8000_0000 + r[3:2];
                    default: p = 32'h7FFF_FFFF - r[3:2];
                endcase
            end
        endcase
        return p;
    endfunction

    initial begin
        int ph;
        int i;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_value_bits <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_FORMAT;
        i_cfg_data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: signed 32-bit, no blanking
        send_value(32'd0);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1_000_000_000);

        // span past the end blanks a zero completely
        set_mode(FMT_S32, 4'd15);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FF9C);

        // spare register indexes must leave the settings alone
        wait_until_drained();
        write_setting(CFG_SPARE_A, 4'hF);
        write_setting(CFG_SPARE_B, 4'h5);
        send_value(32'd100);

        set_mode(FMT_S16, 4'd6);
        send_value(32'd0);
        send_value(32'h0000_7FFF);
        send_value(32'hFFFF_8000);
        send_value(32'h0000_FFFF);
        send_value(32'hABCD_0005);

        set_mode(FMT_U16, 4'd3);
        send_value(32'hFFFF_FFFF);
        send_value(32'd0);
        send_value(32'h1234_0007);

        // undefined format code acts as signed 32-bit
        set_mode(FMT_UNDEF, 4'd11);
        send_value(32'hFFFF_FFFF);
        send_value(32'd5);

        set_mode(FMT_S32, 4'd1);
        send_value(32'd0);

        for (ph = 0; ph < 7; ph++) begin
            set_mode(t_fmt'($urandom_range(0, 3)), BLANK_W'($urandom_range(0, 15)));
            no_idle = (ph == 2);
            if (ph == 4) hold_request = 1'b1;
            for (i = 0; i < 20; i++) begin
                if (ph == 5 && i == 10) wait_until_drained();
                send_value(pick_value());
            end
        end
        no_idle = 1'b0;

        wait_until_drained();
        repeat (4 * TEXT_LEN) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("binary_to_decimal_ascii_test passed");
        end else begin
            $display("binary_to_decimal_ascii_test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/b2d_pkg.sv
design/b2d_cell.sv
design/b2d_conv.sv
design/b2d_emit.sv
design/binary_to_decimal_ascii.sv
design/b2d_checker.sv
dv/binary_to_decimal_ascii_test.sv
